// ===== design/pud_pkg.sv =====
// shared types, character codes and character-class functions for the uri decoder
`timescale 1ns / 1ps
`default_nettype none
package pud_pkg;

   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_ADDR   = 3'd1,
      PH_KEY    = 3'd2,
      PH_VALUE  = 3'd3,
      PH_REJ    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE   = 2'd0,
      ESC_FIRST  = 2'd1,
      ESC_SECOND = 2'd2
   } esc_type;

   typedef enum logic [2:0] {
      KIND_ADDR_BYTE  = 3'd0,
      KIND_KEY_BYTE   = 3'd1,
      KIND_VALUE_BYTE = 3'd2,
      KIND_ADDR_DONE  = 3'd3,
      KIND_PARAM_DONE = 3'd4,
      KIND_ACCEPT     = 3'd5,
      KIND_REJECT     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
   } result_type;

   // results of one request, entry 0 delivered first
   typedef struct packed {
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0]       entry;
   } step_out_type;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   // scheme prefix, lower and upper case letters, colon at the end
   localparam logic [7:0][7:0] SCHEME_LO =
      {8'h3A, 8'h6E, 8'h69, 8'h6F, 8'h63, 8'h74, 8'h69, 8'h62};
   localparam logic [7:0][7:0] SCHEME_UP =
      {8'h3A, 8'h4E, 8'h49, 8'h4F, 8'h43, 8'h54, 8'h49, 8'h42};
   localparam logic [2:0] SCHEME_LAST = 3'd7;

   // returns {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      logic [4:0] r;
      d = 8'h00;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         r = {1'b1, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         r = {1'b1, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         r = {1'b1, d[3:0]};
      end
      return r;
   endfunction

   function automatic logic is_b58(input logic [7:0] c);
      logic r;
      r = 1'b0;
      if (c >= 8'h31 && c <= 8'h39) begin
         r = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = (c != 8'h49) && (c != 8'h4F);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = (c != 8'h6C);
      end
      return r;
   endfunction

   function automatic logic is_query_char(input logic [7:0] c);
      logic r;
      r = 1'b0;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A)) begin
         r = 1'b1;
      end else begin
         unique case (c)
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3A, 8'h40, 8'h2F, 8'h3F: begin
               r = 1'b1;
            end
            default: begin
               r = 1'b0;
            end
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/pud_ifs.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface pud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_uri;
   modport source (output valid, output in_byte, output end_of_uri, input ready);
   modport sink (input valid, input in_byte, input end_of_uri, output ready);
endinterface

interface pud_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] out_byte;
   logic       last_of_run;
   modport source (output valid, output kind, output out_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input kind, input out_byte, input last_of_run,
                 output ready);
endinterface
`default_nettype wire

// ===== design/payment_uri_percent_decode_parser.sv =====
// top level: input register, parse core and result buffer
//
//   channel | direction | contents
//   req     | in        | in_byte, end_of_uri
//   rsp     | out       | kind, out_byte, last_of_run
//   csr     | in        | strict values bit, write only
//
// a request waits in the input register, is decoded combinationally into up to
// three results, which leave the buffer at one per cycle while rsp is ready.
// a request with zero or one result keeps a rate of one request per cycle while
// rsp is ready; one with more results holds the next one until its last is taken.
// synchronous active-high reset empties both registers and restarts at the scheme.
// rsp stalls back up into the input register and then into req.ready.
`timescale 1ns / 1ps
`default_nettype none
module payment_uri_percent_decode_parser (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data,
   pud_req_if.sink   req,
   pud_rsp_if.source rsp
);
   import pud_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         can_load;
   logic         step;
   logic         accept;
   step_out_type step_out;

   assign step      = in_valid_ff && can_load;
   assign req.ready = !in_valid_ff || step;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.end_of_uri;
      end
   end

   pud_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .in_byte     (in_byte_ff),
      .end_of_uri  (in_last_ff),
      .step_out    (step_out)
   );

   pud_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .step_out (step_out),
      .can_load (can_load),
      .rsp      (rsp)
   );

endmodule
`default_nettype wire

// ===== design/pud_core.sv =====
// parse state registers and the per-byte decode step
`timescale 1ns / 1ps
`default_nettype none
module pud_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data,
   input  wire logic               step,
   input  wire logic [7:0]         in_byte,
   input  wire logic               end_of_uri,
   output pud_pkg::step_out_type   step_out
);
   import pud_pkg::*;

   logic      strict_ff;
   phase_type phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   esc_type   esc_ff, esc_in;
   logic [3:0] hi_ff, hi_in;
   logic      run_ne_ff, run_ne_in;
   logic      key_ne_ff, key_ne_in;

   logic       t_emit;
   kind_type   t_kind;
   logic [7:0] t_byte;
   logic [4:0] hex;
   logic       ok;
   logic       f_done;
   logic [1:0] idx;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      esc_in    = esc_ff;
      hi_in     = hi_ff;
      run_ne_in = run_ne_ff;
      key_ne_in = key_ne_ff;
      t_emit    = 1'b0;
      t_kind    = KIND_ADDR_BYTE;
      t_byte    = 8'h00;
      hex       = hex_digit(in_byte);
      ok        = 1'b1;
      f_done    = 1'b0;
      idx       = 2'd0;
      step_out  = '0;

      unique case (phase_ff)
         PH_SCHEME: begin
            if (in_byte == SCHEME_LO[pos_ff] || in_byte == SCHEME_UP[pos_ff]) begin
               if (pos_ff == SCHEME_LAST) begin
                  phase_in = PH_ADDR;
                  pos_in   = 3'd0;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end else begin
               phase_in = PH_REJ;
            end
         end
         PH_ADDR, PH_KEY, PH_VALUE: begin
            if (esc_ff != ESC_NONE) begin
               if (!hex[4]) begin
                  phase_in = PH_REJ;
               end else if (esc_ff == ESC_FIRST) begin
                  hi_in  = hex[3:0];
                  esc_in = ESC_SECOND;
               end else begin
                  t_emit = 1'b1;
                  t_byte = {hi_ff, hex[3:0]};
                  esc_in = ESC_NONE;
                  if (phase_ff == PH_ADDR) begin
                     t_kind    = KIND_ADDR_BYTE;
                     run_ne_in = 1'b1;
                  end else if (phase_ff == PH_KEY) begin
                     t_kind    = KIND_KEY_BYTE;
                     key_ne_in = 1'b1;
                  end else begin
                     t_kind = KIND_VALUE_BYTE;
                  end
               end
            end else if (in_byte == CH_PERCENT) begin
               esc_in = ESC_FIRST;
            end else if (phase_ff == PH_ADDR) begin
               if (is_b58(in_byte)) begin
                  t_emit    = 1'b1;
                  t_kind    = KIND_ADDR_BYTE;
                  t_byte    = in_byte;
                  run_ne_in = 1'b1;
               end else if (in_byte == CH_QUESTION) begin
                  t_emit    = run_ne_ff;
                  t_kind    = KIND_ADDR_DONE;
                  phase_in  = PH_KEY;
                  key_ne_in = 1'b0;
               end else begin
                  phase_in = PH_REJ;
               end
            end else if (phase_ff == PH_KEY) begin
               if (is_query_char(in_byte)) begin
                  t_emit    = 1'b1;
                  t_kind    = KIND_KEY_BYTE;
                  t_byte    = in_byte;
                  key_ne_in = 1'b1;
               end else if (in_byte == CH_EQUAL) begin
                  phase_in = key_ne_ff ? PH_VALUE : PH_REJ;
               end else if (in_byte == CH_AMP) begin
                  t_emit    = key_ne_ff;
                  t_kind    = KIND_PARAM_DONE;
                  key_ne_in = 1'b0;
               end else begin
                  phase_in = PH_REJ;
               end
            end else begin
               if (in_byte == CH_AMP) begin
                  t_emit    = 1'b1;
                  t_kind    = KIND_PARAM_DONE;
                  phase_in  = PH_KEY;
                  key_ne_in = 1'b0;
               end else if (!strict_ff || is_query_char(in_byte)) begin
                  t_emit = 1'b1;
                  t_kind = KIND_VALUE_BYTE;
                  t_byte = in_byte;
               end else begin
                  phase_in = PH_REJ;
               end
            end
         end
         default: begin
            phase_in = PH_REJ;
         end
      endcase

      if (t_emit) begin
         step_out.entry[idx] = '{kind: t_kind, out_byte: t_byte};
         idx = idx + 2'd1;
      end

      if (end_of_uri) begin
         // closing event on the state left by this byte
         if (esc_in != ESC_NONE) begin
            ok = 1'b0;
         end else begin
            unique case (phase_in)
               PH_ADDR:  f_done = run_ne_in;
               PH_KEY:   f_done = key_ne_in;
               PH_VALUE: f_done = 1'b1;
               default:  ok = 1'b0;
            endcase
         end
         if (f_done) begin
            step_out.entry[idx] =
               '{kind: (phase_in == PH_ADDR) ? KIND_ADDR_DONE : KIND_PARAM_DONE,
                 out_byte: 8'h00};
            idx = idx + 2'd1;
         end
         step_out.entry[idx] = '{kind: ok ? KIND_ACCEPT : KIND_REJECT, out_byte: 8'h00};
         idx = idx + 2'd1;
         phase_in  = PH_SCHEME;
         pos_in    = 3'd0;
         esc_in    = ESC_NONE;
         hi_in     = 4'd0;
         run_ne_in = 1'b0;
         key_ne_in = 1'b0;
      end
      step_out.count = idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SCHEME;
         pos_ff    <= 3'd0;
         esc_ff    <= ESC_NONE;
         hi_ff     <= 4'd0;
         run_ne_ff <= 1'b0;
         key_ne_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         esc_ff    <= esc_in;
         hi_ff     <= hi_in;
         run_ne_ff <= run_ne_in;
         key_ne_ff <= key_ne_in;
      end
   end

   // a scheme mismatch keeps its position until the last byte
   a_pos_only_in_scheme: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 3'd0) |-> (phase_ff == PH_SCHEME || phase_ff == PH_REJ))
      else $error("scheme position set outside scheme phase");

   a_esc_only_in_runs: assert property (@(posedge clock) disable iff (reset)
      (esc_ff != ESC_NONE) |-> (phase_ff != PH_SCHEME))
      else $error("escape pending outside a decoding phase");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && end_of_uri) |=> (phase_ff == PH_SCHEME && esc_ff == ESC_NONE))
      else $error("parser not restarted after last byte");

endmodule
`default_nettype wire

// ===== design/pud_outq.sv =====
// three-entry result buffer that hands out one result per cycle while rsp is ready
`timescale 1ns / 1ps
`default_nettype none
module pud_outq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire pud_pkg::step_out_type  step_out,
   output logic                        can_load,
   pud_rsp_if.source                   rsp
);
   import pud_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type q_ff [MAX_RESULTS];
   result_type q_in [MAX_RESULTS];
   logic       pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp.ready);

   assign rsp.valid       = (count_ff != 2'd0);
   assign rsp.kind        = q_ff[0].kind;
   assign rsp.out_byte    = q_ff[0].out_byte;
   assign rsp.last_of_run = (count_ff == 2'd1);

   always_comb begin
      count_in = count_ff;
      q_in     = q_ff;
      if (load) begin
         count_in = step_out.count;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            q_in[i] = step_out.entry[i];
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   a_event_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.kind == KIND_ADDR_DONE || rsp.kind == KIND_PARAM_DONE ||
                     rsp.kind == KIND_ACCEPT || rsp.kind == KIND_REJECT))
         |-> (rsp.out_byte == 8'h00))
      else $error("event result carries a nonzero byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == 2'd0 || (count_ff == 2'd1 && pop)))
      else $error("results overwritten before delivery");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !load && count_ff >= 2'd2) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("buffer count lost track on delivery");

endmodule
`default_nettype wire

// ===== tb/tb_payment_uri_percent_decode_parser.sv =====
// testbench for the payment uri percent decoder: directed and random uris checked against a predictor
`timescale 1ns / 1ps
module tb_payment_uri_percent_decode_parser;
   import pud_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } decoded_result;

   class decode_scoreboard;
      decoded_result due[$];
      decoded_result step_out[$];
      bit            strict;
      phase_type     phase;
      logic [2:0]    scheme_pos;
      esc_type       esc;
      logic [3:0]    high_nib;
      bit            addr_seen;
      bit            key_seen;
      int            errors;

      function new();
         strict = 1'b1;
         errors = 0;
         restart();
      endfunction

      function void restart();
         phase = PH_SCHEME;
         scheme_pos = '0;
         esc = ESC_NONE;
         high_nib = '0;
         addr_seen = 1'b0;
         key_seen = 1'b0;
      endfunction

      // {valid, value}
      function logic [4:0] hex_nibble(input logic [7:0] c);
         logic [4:0] r;
         r = '0;
         if (c >= "0" && c <= "9") begin
            r = {1'b1, c[3:0]};
         end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            r = {1'b1, c[3:0] + 4'd9};
         end
         return r;
      endfunction

      function bit base58_char(input logic [7:0] c);
         return (c >= "1" && c <= "9") ||
                (c >= "A" && c <= "Z" && c != "I" && c != "O") ||
                (c >= "a" && c <= "z" && c != "l");
      endfunction

      function bit query_char(input logic [7:0] c);
         bit r;
         r = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
         case (c)
            "-", ".", "_", "~", "!", "$", "'", "(", ")", "*", "+", ",", ";", ":", "@", "/",
            "?": begin
               r = 1'b1;
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void emit(input kind_type k, input logic [7:0] d);
         decoded_result e;
         e.kind = k;
         e.data = d;
         e.last = 1'b0;
         if (step_out.size() < MAX_RESULTS) begin
            step_out = {step_out, e};
         end
      endfunction

      function void note_request(input logic [7:0] c, input logic last);
         logic [4:0]    h;
         kind_type      k;
         bit            ok;
         decoded_result e;
         step_out.delete();
         h = hex_nibble(c);
         if (phase == PH_SCHEME) begin
            if (c == SCHEME_LO[scheme_pos] || c == SCHEME_UP[scheme_pos]) begin
               if (scheme_pos == SCHEME_LAST) begin
                  phase = PH_ADDR;
                  scheme_pos = '0;
               end else begin
                  scheme_pos = scheme_pos + 3'd1;
               end
            end else begin
               phase = PH_REJ;
            end
         end else if (phase == PH_REJ) begin
            // rejected: wait for the end of the uri
         end else if (esc != ESC_NONE) begin
            if (!h[4]) begin
               phase = PH_REJ;
            end else if (esc == ESC_FIRST) begin
               high_nib = h[3:0];
               esc = ESC_SECOND;
            end else begin
               case (phase)
                  PH_ADDR: k = KIND_ADDR_BYTE;
                  PH_KEY:  k = KIND_KEY_BYTE;
                  default: k = KIND_VALUE_BYTE;
               endcase
               emit(k, {high_nib, h[3:0]});
               esc = ESC_NONE;
               if (phase == PH_ADDR) begin
                  addr_seen = 1'b1;
               end else if (phase == PH_KEY) begin
                  key_seen = 1'b1;
               end
            end
         end else if (c == CH_PERCENT) begin
            esc = ESC_FIRST;
         end else begin
            case (phase)
               PH_ADDR: begin
                  if (base58_char(c)) begin
                     emit(KIND_ADDR_BYTE, c);
                     addr_seen = 1'b1;
                  end else if (c == CH_QUESTION) begin
                     if (addr_seen) begin
                        emit(KIND_ADDR_DONE, 8'h00);
                     end
                     phase = PH_KEY;
                     key_seen = 1'b0;
                  end else begin
                     phase = PH_REJ;
                  end
               end
               PH_KEY: begin
                  if (query_char(c)) begin
                     emit(KIND_KEY_BYTE, c);
                     key_seen = 1'b1;
                  end else if (c == CH_EQUAL) begin
                     phase = key_seen ? PH_VALUE : PH_REJ;
                  end else if (c == CH_AMP) begin
                     if (key_seen) begin
                        emit(KIND_PARAM_DONE, 8'h00);
                     end
                     key_seen = 1'b0;
                  end else begin
                     phase = PH_REJ;
                  end
               end
               default: begin
                  if (c == CH_AMP) begin
                     emit(KIND_PARAM_DONE, 8'h00);
                     phase = PH_KEY;
                     key_seen = 1'b0;
                  end else if (!strict || query_char(c)) begin
                     emit(KIND_VALUE_BYTE, c);
                  end else begin
                     phase = PH_REJ;
                  end
               end
            endcase
         end
         if (last) begin
            ok = 1'b1;
            if (esc != ESC_NONE) begin
               ok = 1'b0;
            end else begin
               case (phase)
                  PH_ADDR: begin
                     if (addr_seen) begin
                        emit(KIND_ADDR_DONE, 8'h00);
                     end
                  end
                  PH_KEY: begin
                     if (key_seen) begin
                        emit(KIND_PARAM_DONE, 8'h00);
                     end
                  end
                  PH_VALUE: begin
                     emit(KIND_PARAM_DONE, 8'h00);
                  end
                  default: begin
                     ok = 1'b0;
                  end
               endcase
            end
            if (ok) begin
               emit(KIND_ACCEPT, 8'h00);
            end else begin
               emit(KIND_REJECT, 8'h00);
            end
            restart();
         end
         foreach (step_out[i]) begin
            e = step_out[i];
            e.last = (i == step_out.size() - 1);
            due = {due, e};
         end
      endfunction

      function void check_result(input logic [2:0] kind, input logic [7:0] data,
                                 input logic last);
         decoded_result e;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result: kind %0d byte %02h last %0b", kind, data, last);
            end
         end else begin
            e = due.pop_front();
            if (e.kind !== kind || e.data !== data || e.last !== last) begin
               errors++;
               if (errors <= 10) begin
                  $display("result error: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                           e.kind, e.data, e.last, kind, data, last);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   logic rsp_hold;
   bit   send_quiet;
   bit   recv_quiet;
   event hold_kick;

   decode_scoreboard sb;
   logic [7:0]       uri_bytes[$];
   string b58_chars = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
   string query_chars =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-._~!$'()*+,;:@/?";

   pud_req_if req_if();
   pud_rsp_if rsp_if();

   payment_uri_percent_decode_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_if),
      .rsp         (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'd0, n};
      end
      return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      uri_bytes = {uri_bytes, b};
   endtask

   task automatic add_escape(input logic [7:0] v);
      put_byte(CH_PERCENT);
      put_byte(hex_char(v[7:4]));
      put_byte(hex_char(v[3:0]));
   endtask

   task automatic add_scheme(input logic [7:0] upper_mask);
      for (int i = 0; i < 8; i++) begin
         put_byte(upper_mask[i] ? SCHEME_UP[i] : SCHEME_LO[i]);
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         put_byte(s[i]);
      end
   endtask

   task automatic add_query_byte();
      if ($urandom_range(0, 4) == 0) begin
         add_escape(8'($urandom_range(0, 255)));
      end else begin
         put_byte(query_chars[$urandom_range(0, query_chars.len() - 1)]);
      end
   endtask

   task automatic add_value_byte();
      logic [7:0] b;
      if (sb.strict || $urandom_range(0, 4) == 0) begin
         add_query_byte();
      end else if ($urandom_range(0, 5) == 0) begin
         put_byte(CH_EQUAL);
      end else begin
         // any byte but the separator; a percent would open an escape
         do begin
            b = 8'($urandom_range(0, 255));
         end while (b == CH_AMP || b == CH_PERCENT);
         put_byte(b);
      end
   endtask

   task automatic build_random_uri();
      int shape;
      int n;
      int params;
      int klen;
      int pos;
      shape = $urandom_range(0, 9);
      if (shape < 2) begin
         // noise, sometimes behind a good scheme
         if (shape == 1) begin
            add_scheme(8'($urandom_range(0, 255)));
         end
         n = $urandom_range(1, 5);
         repeat (n) put_byte(8'($urandom_range(0, 255)));
      end else begin
         add_scheme(8'($urandom_range(0, 255)));
         n = $urandom_range(0, 5);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               add_escape(8'($urandom_range(0, 255)));
            end else begin
               put_byte(b58_chars[$urandom_range(0, b58_chars.len() - 1)]);
            end
         end
         if ($urandom_range(0, 5) != 0) begin
            put_byte(CH_QUESTION);
            params = $urandom_range(0, 3);
            for (int p = 0; p < params; p++) begin
               if (p > 0) begin
                  put_byte(CH_AMP);
               end
               klen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
               repeat (klen) add_query_byte();
               if ($urandom_range(0, 3) != 0) begin
                  put_byte(CH_EQUAL);
                  n = $urandom_range(0, 4);
                  repeat (n) add_value_byte();
               end
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            // one fault: a stray byte, or the uri cut short
            if (uri_bytes.size() > 8 && $urandom_range(0, 3) != 0) begin
               pos = $urandom_range(8, uri_bytes.size() - 1);
            end else begin
               pos = $urandom_range(0, uri_bytes.size() - 1);
            end
            if ($urandom_range(0, 1) == 0) begin
               uri_bytes[pos] = 8'($urandom_range(0, 255));
            end else begin
               while (uri_bytes.size() > pos + 1) begin
                  void'(uri_bytes.pop_back());
               end
            end
         end
      end
   endtask

   task automatic send_request(input logic [7:0] b, input logic last);
      int gap;
      if ($urandom_range(0, 24) == 0) begin
         send_quiet = !send_quiet;
      end
      gap = send_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.end_of_uri <= last;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      sb.note_request(b, last);
   endtask

   task automatic send_uri();
      for (int i = 0; i < uri_bytes.size(); i++) begin
         send_request(uri_bytes[i], i == uri_bytes.size() - 1);
      end
      uri_bytes.delete();
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_strict(input bit v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.strict = v;
   endtask

   task automatic run_random(input int byte_target);
      int sent;
      sent = 0;
      while (sent < byte_target) begin
         build_random_uri();
         sent += uri_bytes.size();
         send_uri();
      end
      drain();
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.kind, rsp_if.out_byte, rsp_if.last_of_run);
            if ($urandom_range(0, 24) == 0) begin
               recv_quiet = !recv_quiet;
            end
            stall_left = recv_quiet ? 0 : $urandom_range(0, 17);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= (stall_left == 0) && !rsp_hold;
      end
   end

   // long receiver stall so the block backs up into the request side
   initial begin : hold_off
      rsp_hold = 1'b0;
      @(hold_kick);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (120) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #3000000;
      $display("payment_uri_percent_decode_parser: mismatch");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_if.valid = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.end_of_uri = 1'b0;
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_strict(1'b1);

      // lowest byte as a whole uri, then highest byte followed by an ignored one
      put_byte(8'h00);
      send_uri();
      put_byte(8'hFF);
      put_byte(SCHEME_UP[0]);
      send_uri();
      // scheme cut short
      put_byte(SCHEME_LO[0]);
      send_uri();
      // escaped address byte, then an empty key before '='
      add_scheme(8'h55);
      add_escape(8'hFF);
      put_byte(CH_QUESTION);
      put_byte(CH_EQUAL);
      send_uri();
      add_scheme(8'hAA);
      add_text("z?k=v");
      send_uri();
      drain();

      write_strict(1'b0);
      -> hold_kick;
      run_random(50);
      write_strict(1'b1);
      run_random(50);
      write_strict(1'b0);
      run_random(50);
      write_strict(1'b1);
      run_random(50);

      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("payment_uri_percent_decode_parser: match");
      end else begin
         $display("payment_uri_percent_decode_parser: mismatch");
      end
      $finish;
   end

endmodule
